>>> rtl/core/sliding_window_min_max_sum_unit_macros.svh
// ---------------------------------------------------------------------------
// sliding window unit assertion macros
// shared concurrent check helpers for the sliding window unit
// ---------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_MIN_MAX_SUM_UNIT_MACROS_SVH
`define SLIDING_WINDOW_MIN_MAX_SUM_UNIT_MACROS_SVH

// same-cycle implication, muted during reset
`define SWMMS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, muted during reset
`define SWMMS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/swmms_pkg.sv
// ---------------------------------------------------------------------------
// swmms_pkg
// types, constants and control structs of the sliding window unit
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package swmms_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int SAMPLE_W     = 32;
  localparam int SUM_W        = 40;
  localparam int COUNT_OUT_W  = 7;
  localparam int KIND_W       = 2;
  localparam int DIV_STEPS    = SUM_W;
  localparam int OUT_FIELDS_W = 4 * SAMPLE_W + SUM_W + COUNT_OUT_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic [SAMPLE_W-1:0] Q_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic [SAMPLE_W-1:0] Q_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  // operation codes carried in s_tuser
  localparam logic [KIND_W-1:0] KIND_PUSH  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PUSH,
    ST_SCAN,
    ST_SCAN_END,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_CLEAR,
    ST_EMIT,
    ST_RD_INIT,
    ST_RD_ADDR,
    ST_RD_EMIT
  } state_t;

  typedef enum logic [1:0] {
    RD_SEL_WP,
    RD_SEL_SCAN,
    RD_SEL_POS
  } rd_sel_t;

  typedef struct packed {
    logic    capture;
    logic    push_apply;
    logic    clear;
    logic    scan_issue;
    logic    div_start;
    logic    emit_aggr;
    logic    rd_init;
    logic    rd_emit;
    rd_sel_t rd_sel;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic count_zero;
    logic need_rescan;
    logic scan_last;
    logic div_done;
    logic out_free;
    logic rd_last;
  } status_t;

endpackage

>>> rtl/core/sliding_window_min_max_sum_unit.sv
// a push result is registered after the update, the divide start, the divide and the
// output load, which waits for a free output register
// a push that evicts the current minimum or maximum adds a rescan over every ring position
// clear resets the window and emits one result; read-out gives the held items oldest first
// one input item is in work at a time; the next is taken once its last result is registered
// reset clears the window state and control at once; the ring has no clearing pass
// ---------------------------------------------------------------------------
// sliding_window_min_max_sum_unit
// windowed min, max, sum and average over the last CAPACITY Q16.16 samples
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "sliding_window_min_max_sum_unit_macros.svh"

module sliding_window_min_max_sum_unit #(
  parameter int CAPACITY = swmms_pkg::CAPACITY_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [swmms_pkg::SAMPLE_W-1:0]    s_tdata,  // sample
  input  logic [swmms_pkg::KIND_W-1:0]      s_tuser,  // kind
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // item_value, entry_count, min_value, max_value, sum_value, average_value, zero pad
  output logic [swmms_pkg::OUT_TDATA_W-1:0] m_tdata,
  output logic                              m_tlast
);

  import swmms_pkg::*;

  cmd_t    cmd;
  status_t status;

  // sequencer
  swmms_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .status   (status),
    .cmd      (cmd)
  );

  // window datapath
  swmms_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // checks
  `SWMMS_ASSERT_NOW(a_load_when_free, clk, rst, (cmd.emit_aggr || cmd.rd_emit), status.out_free, "output register overwritten while full")
  `SWMMS_ASSERT_NEXT(a_aggr_item_last, clk, rst, cmd.emit_aggr, (m_tvalid && m_tlast), "single result item not marked last")
  `SWMMS_ASSERT_NOW(a_count_bound, clk, rst, m_tvalid, (m_tdata[38:32] <= COUNT_OUT_W'(CAPACITY)), "entry count beyond capacity")
  `SWMMS_ASSERT_NOW(a_avg_in_range, clk, rst, (m_tvalid && m_tdata[38:32] != '0), ($signed(m_tdata[70:39]) <= $signed(m_tdata[174:143]) && $signed(m_tdata[174:143]) <= $signed(m_tdata[102:71])), "average outside min and max")

endmodule

>>> rtl/core/swmms_ram.sv
// ---------------------------------------------------------------------------
// swmms_ram
// generic single write port, single read port ram with registered read
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module swmms_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

>>> rtl/core/swmms_div.sv
// ---------------------------------------------------------------------------
// swmms_div
// restoring divider, signed sum by unsigned count, one quotient bit a cycle
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module swmms_div #(
  parameter int CNT_W = 7
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [swmms_pkg::SUM_W-1:0]   dividend,
  input  logic [CNT_W-1:0]              divisor,
  output logic                          done,
  output logic [swmms_pkg::SAMPLE_W-1:0] quotient
);

  import swmms_pkg::*;

  localparam int STEP_W = $clog2(DIV_STEPS);

  logic              busy;
  logic [STEP_W-1:0] step;
  logic              negative;
  logic [SUM_W-1:0]  mag;
  logic [CNT_W-1:0]  rem;
  logic [CNT_W:0]    trial;
  logic              fits;
  logic [CNT_W:0]    diff;

  // one trial subtraction per cycle
  always_comb begin
    trial = {rem, mag[SUM_W-1]};
    fits  = trial >= {1'b0, divisor};
    diff  = trial - {1'b0, divisor};
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // magnitude shift register and partial remainder
  always_ff @(posedge clk) begin
    if (start) begin
      negative <= dividend[SUM_W-1];
      mag      <= dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
      rem      <= '0;
    end else if (busy) begin
      mag <= {mag[SUM_W-2:0], fits};
      rem <= fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
    end
  end

  // quotient magnitude fits the sample width, sign restored here
  assign quotient = negative ? (~mag[SAMPLE_W-1:0] + 1'b1) : mag[SAMPLE_W-1:0];

endmodule

>>> rtl/core/swmms_datapath.sv
// ---------------------------------------------------------------------------
// swmms_datapath
// sample ring, running aggregates, rescan, read-out pointer and output register
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module swmms_datapath #(
  parameter int CAPACITY = swmms_pkg::CAPACITY_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  swmms_pkg::cmd_t                   cmd,
  output swmms_pkg::status_t                status,
  input  logic [swmms_pkg::SAMPLE_W-1:0]    s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [swmms_pkg::OUT_TDATA_W-1:0] m_tdata,
  output logic                              m_tlast
);

  import swmms_pkg::*;

  localparam int PTR_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(CAPACITY - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);
  localparam int PAD_W = OUT_TDATA_W - OUT_FIELDS_W;

  logic [SAMPLE_W-1:0] sample;
  logic [PTR_W-1:0]    wp;
  logic [CNT_W-1:0]    count;
  logic [SAMPLE_W-1:0] wmin;
  logic [SAMPLE_W-1:0] wmax;
  logic [SUM_W-1:0]    wsum;
  logic [SAMPLE_W-1:0] avg;
  logic [PTR_W-1:0]    scan_cnt;
  logic                scan_valid;
  logic [PTR_W-1:0]    rd_pos;
  logic [CNT_W-1:0]    rd_left;

  logic [PTR_W-1:0]    rd_addr;
  logic [SAMPLE_W-1:0] rd_data;
  logic [SAMPLE_W-1:0] wmin_next;
  logic [SAMPLE_W-1:0] wmax_next;
  logic [SUM_W-1:0]    wsum_next;
  logic [SUM_W-1:0]    evict_ext;
  logic                full;
  logic                need_rescan;
  logic [PTR_W-1:0]    wp_next;
  logic [PTR_W:0]      oldest_raw;
  logic [PTR_W-1:0]    oldest;
  logic                div_done;
  logic [SAMPLE_W-1:0] quotient;
  logic                out_free;
  logic                load;

  logic [SAMPLE_W-1:0]    out_item;
  logic [COUNT_OUT_W-1:0] out_count;
  logic [SAMPLE_W-1:0]    out_min;
  logic [SAMPLE_W-1:0]    out_max;
  logic [SUM_W-1:0]       out_sum;
  logic [SAMPLE_W-1:0]    out_avg;
  logic                   out_last;
  logic [SAMPLE_W-1:0]    load_item;

  // ring memory
  always_comb begin
    case (cmd.rd_sel)
      RD_SEL_WP:   rd_addr = wp;
      RD_SEL_SCAN: rd_addr = scan_cnt;
      RD_SEL_POS:  rd_addr = rd_pos;
      default:     rd_addr = wp;
    endcase
  end

  swmms_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (CAPACITY)
  ) u_ring (
    .clk     (clk),
    .wr_en   (cmd.push_apply),
    .wr_addr (wp),
    .wr_data (sample),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // push arithmetic, evicted sample arrives from the ring read
  always_comb begin
    full      = count == FULL_CNT;
    wmin_next = ($signed(sample) < $signed(wmin)) ? sample : wmin;
    wmax_next = ($signed(sample) > $signed(wmax)) ? sample : wmax;
    evict_ext = full ? {{(SUM_W-SAMPLE_W){rd_data[SAMPLE_W-1]}}, rd_data} : '0;
    wsum_next = wsum + {{(SUM_W-SAMPLE_W){sample[SAMPLE_W-1]}}, sample} - evict_ext;
    need_rescan = full && (rd_data == wmin_next || rd_data == wmax_next);
    wp_next   = (wp == LAST_PTR) ? '0 : wp + 1'b1;
  end

  // oldest held position, wraps with one compare and subtract
  always_comb begin
    oldest_raw = (PTR_W+1)'(wp) + (PTR_W+1)'(CAPACITY) - (PTR_W+1)'(count);
    oldest     = (oldest_raw >= (PTR_W+1)'(CAPACITY)) ?
                 PTR_W'(oldest_raw - (PTR_W+1)'(CAPACITY)) : oldest_raw[PTR_W-1:0];
  end

  // sample capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sample <= s_tdata;
    end
  end

  // window state
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      wp    <= '0;
      count <= '0;
      wmin  <= Q_MAX;
      wmax  <= Q_MIN;
      wsum  <= '0;
    end else if (cmd.push_apply) begin
      wp    <= wp_next;
      wsum  <= wsum_next;
      if (!full) begin
        count <= count + 1'b1;
      end
      wmin  <= need_rescan ? Q_MAX : wmin_next;
      wmax  <= need_rescan ? Q_MIN : wmax_next;
    end else if (scan_valid) begin
      if ($signed(rd_data) < $signed(wmin)) begin
        wmin <= rd_data;
      end
      if ($signed(rd_data) > $signed(wmax)) begin
        wmax <= rd_data;
      end
    end
  end

  // rescan walk over every position, only a full window is rescanned
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_valid <= 1'b0;
      scan_cnt   <= '0;
    end else begin
      scan_valid <= cmd.scan_issue;
      if (cmd.push_apply) begin
        scan_cnt <= '0;
      end else if (cmd.scan_issue) begin
        scan_cnt <= scan_cnt + 1'b1;
      end
    end
  end

  // average
  swmms_div #(
    .CNT_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (wsum),
    .divisor  (count),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (div_done) begin
      avg <= quotient;
    end
  end

  // read-out pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_left <= '0;
    end else if (cmd.rd_init) begin
      rd_left <= count;
    end else if (cmd.rd_emit) begin
      rd_left <= rd_left - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_init) begin
      rd_pos <= oldest;
    end else if (cmd.rd_emit) begin
      rd_pos <= (rd_pos == LAST_PTR) ? '0 : rd_pos + 1'b1;
    end
  end

  // output register
  assign out_free  = !m_tvalid || m_tready;
  assign load      = cmd.emit_aggr || cmd.rd_emit;
  assign load_item = cmd.rd_emit ? rd_data : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_item  <= load_item;
      out_count <= COUNT_OUT_W'(count);
      out_min   <= (count == '0) ? '0 : wmin;
      out_max   <= (count == '0) ? '0 : wmax;
      out_sum   <= (count == '0) ? '0 : wsum;
      out_avg   <= (count == '0) ? '0 : avg;
      out_last  <= cmd.emit_aggr || (rd_left == CNT_W'(1));
    end
  end

  assign m_tdata = {{PAD_W{1'b0}}, out_avg, out_sum, out_max, out_min, out_count, out_item};
  assign m_tlast = out_last;

  // status back to the controller
  always_comb begin
    status.full        = full;
    status.count_zero  = count == '0;
    status.need_rescan = need_rescan;
    status.scan_last   = scan_cnt == LAST_PTR;
    status.div_done    = div_done;
    status.out_free    = out_free;
    status.rd_last     = rd_left == CNT_W'(1);
  end

endmodule

>>> rtl/core/swmms_ctrl.sv
// ---------------------------------------------------------------------------
// swmms_ctrl
// operation sequencer for push, clear and read-out of the sliding window
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module swmms_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [swmms_pkg::KIND_W-1:0]  s_tuser,
  input  swmms_pkg::status_t            status,
  output swmms_pkg::cmd_t               cmd
);

  import swmms_pkg::*;

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          case (s_tuser)
            KIND_PUSH:  state_next = ST_PUSH;
            KIND_CLEAR: state_next = ST_CLEAR;
            KIND_READ:  state_next = status.count_zero ? ST_EMIT : ST_RD_INIT;
            default:    state_next = ST_IDLE;
          endcase
        end
      end
      ST_PUSH:      state_next = status.need_rescan ? ST_SCAN : ST_DIV_START;
      ST_SCAN:      state_next = status.scan_last ? ST_SCAN_END : ST_SCAN;
      ST_SCAN_END:  state_next = ST_DIV_START;
      ST_DIV_START: state_next = ST_DIV_WAIT;
      ST_DIV_WAIT:  state_next = status.div_done ? ST_EMIT : ST_DIV_WAIT;
      ST_CLEAR:     state_next = ST_EMIT;
      ST_EMIT:      state_next = status.out_free ? ST_IDLE : ST_EMIT;
      ST_RD_INIT:   state_next = ST_RD_ADDR;
      ST_RD_ADDR:   state_next = ST_RD_EMIT;
      ST_RD_EMIT: begin
        if (status.out_free) begin
          state_next = status.rd_last ? ST_IDLE : ST_RD_ADDR;
        end
      end
      default:      state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    cmd.rd_sel = RD_SEL_WP;
    case (state)
      ST_IDLE: begin
        s_tready    = 1'b1;
        cmd.capture = s_tvalid;
      end
      ST_PUSH:      cmd.push_apply = 1'b1;
      ST_SCAN: begin
        cmd.scan_issue = 1'b1;
        cmd.rd_sel     = RD_SEL_SCAN;
      end
      ST_DIV_START: cmd.div_start = 1'b1;
      ST_CLEAR:     cmd.clear = 1'b1;
      ST_EMIT:      cmd.emit_aggr = status.out_free;
      ST_RD_INIT:   cmd.rd_init = 1'b1;
      ST_RD_ADDR:   cmd.rd_sel = RD_SEL_POS;
      ST_RD_EMIT: begin
        cmd.rd_sel  = RD_SEL_POS;
        cmd.rd_emit = status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule
